/* src/shape_span_compressor_core_defines.svh */
// Assertion macros shared by the shape span compressor RTL.
`ifndef SHAPE_SPAN_COMPRESSOR_CORE_DEFINES_SVH
`define SHAPE_SPAN_COMPRESSOR_CORE_DEFINES_SVH

// Condition must hold in the same cycle as the antecedent.
`define SSC_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define SSC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ssc_pkg.sv */
// Shared constants, types and helper functions of the shape span compressor.
package ssc_pkg;

    // Default store depth.
    localparam int MAX_RECTS_DEF = 64;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int EDGE_W  = 17;
    localparam int SQ_W    = 19;
    localparam int FIELD_W = 16;
    localparam int HASH_W  = 32;
    localparam int COUNT_W = 7;

    // Hash weights.
    localparam logic [HASH_W-1:0] HASH_MUL  = 32'd31;
    localparam logic [HASH_W-1:0] HASH_K_X1 = 32'd17;
    localparam logic [HASH_W-1:0] HASH_K_X2 = 32'd27;
    localparam logic [HASH_W-1:0] HASH_K_Y1 = 32'd37;
    localparam logic [HASH_W-1:0] HASH_K_Y2 = 32'd43;

    // One stored rectangle: top-left corner and bottom-right edges.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [EDGE_W-1:0]  x2;
        logic signed [EDGE_W-1:0]  y2;
    } rect_ent_t;

    localparam int ENT_W = $bits(rect_ent_t);

    // Working width for squeezed coordinates.
    typedef logic signed [SQ_W-1:0] sq_t;

    // Collapse the part of a coordinate that lies inside span [a, b).
    function automatic sq_t squeeze(sq_t v, sq_t a, sq_t b);
        sq_t lim;
        sq_t m;
        lim = b - sq_t'(1);
        m = (v < lim) ? v : lim;
        squeeze = (v > a) ? (v - m + a) : v;
    endfunction

    // Low bits of a signed difference, two's complement.
    function automatic logic [FIELD_W-1:0] fld(sq_t v);
        fld = v[FIELD_W-1:0];
    endfunction

    // Sign extension of a squeezed value to the hash width.
    function automatic logic [HASH_W-1:0] hx(sq_t v);
        hx = HASH_W'(v);
    endfunction

endpackage

/* src/ssc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ssc_ram #(
    parameter int WIDTH = ssc_pkg::ENT_W,
    parameter int DEPTH = ssc_pkg::MAX_RECTS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/shape_span_compressor_core.sv */
// Shape span compressor: loads a banded region and emits it with common spans collapsed.
//
// Rectangles load at one request per cycle, while in_stall is low, into a store of MAX_RECTS
// entries; the bounding extents, the tallest band span and the intersection of the bands'
// widest spans are updated on the fly. The request that ends the region starts two walks
// over the store through its single read port: a hash walk, then an emit walk of one result
// per cycle while the output is not stalled. No input is taken during the walks. An empty
// region marker produces one all-zero result with last_result set once the output register
// is free.
`include "shape_span_compressor_core_defines.svh"

module shape_span_compressor_core #(
    parameter int MAX_RECTS = ssc_pkg::MAX_RECTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic signed [ssc_pkg::COORD_W-1:0]   rect_x,
    input  logic signed [ssc_pkg::COORD_W-1:0]   rect_y,
    input  logic [ssc_pkg::SIZE_W-1:0]           rect_width,
    input  logic [ssc_pkg::SIZE_W-1:0]           rect_height,
    input  logic                                 band_end,
    input  logic                                 region_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ssc_pkg::FIELD_W-1:0]          out_x,
    output logic [ssc_pkg::FIELD_W-1:0]          out_y,
    output logic [ssc_pkg::FIELD_W-1:0]          out_width,
    output logic [ssc_pkg::FIELD_W-1:0]          out_height,
    output logic [ssc_pkg::FIELD_W-1:0]          margin_top,
    output logic [ssc_pkg::FIELD_W-1:0]          margin_right,
    output logic [ssc_pkg::FIELD_W-1:0]          margin_bottom,
    output logic [ssc_pkg::FIELD_W-1:0]          margin_left,
    output logic [ssc_pkg::HASH_W-1:0]           shape_hash,
    output logic [ssc_pkg::COUNT_W-1:0]          rect_count,
    output logic                                 last_result
);

    import ssc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int ADDR_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    typedef enum logic [1:0] {S_LOAD, S_EMPTY, S_HASH, S_EMIT} state_t;

    // Control and run state.
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic                      rd_last_reg, rd_last_next;
    logic                      sq_valid_reg, sq_valid_next;
    logic                      first_band_reg, first_band_next;
    logic                      bw_valid_reg, bw_valid_next;
    logic signed [COORD_W-1:0] ext_x1_reg, ext_x1_next;
    logic signed [COORD_W-1:0] ext_y1_reg, ext_y1_next;
    logic signed [EDGE_W-1:0]  ext_x2_reg, ext_x2_next;
    logic signed [EDGE_W-1:0]  ext_y2_reg, ext_y2_next;
    logic signed [EDGE_W-1:0]  vs_a_reg, vs_a_next;
    logic signed [EDGE_W-1:0]  vs_b_reg, vs_b_next;
    logic [SIZE_W-1:0]         vs_len_reg, vs_len_next;
    logic signed [EDGE_W-1:0]  hs_a_reg, hs_a_next;
    logic signed [EDGE_W-1:0]  hs_b_reg, hs_b_next;
    logic signed [EDGE_W-1:0]  bw_a_reg, bw_a_next;
    logic signed [EDGE_W-1:0]  bw_b_reg, bw_b_next;
    logic [SIZE_W-1:0]         bw_len_reg, bw_len_next;
    logic [HASH_W-1:0]         hash_reg, hash_next;

    // Squeezed coordinates between the read and the hash update.
    sq_t sq_x1_reg, sq_x1_next;
    sq_t sq_x2_reg, sq_x2_next;
    sq_t sq_y1_reg, sq_y1_next;
    sq_t sq_y2_reg, sq_y2_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]    out_x_reg, out_x_next;
    logic [FIELD_W-1:0]    out_y_reg, out_y_next;
    logic [FIELD_W-1:0]    out_w_reg, out_w_next;
    logic [FIELD_W-1:0]    out_h_reg, out_h_next;
    logic [FIELD_W-1:0]    bd_top_reg, bd_top_next;
    logic [FIELD_W-1:0]    bd_right_reg, bd_right_next;
    logic [FIELD_W-1:0]    bd_bottom_reg, bd_bottom_next;
    logic [FIELD_W-1:0]    bd_left_reg, bd_left_next;
    logic [HASH_W-1:0]     out_hash_reg, out_hash_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    // Store interface.
    logic                  st_we;
    logic                  st_re;
    rect_ent_t             st_wdata;
    logic [ENT_W-1:0]      st_rdata;
    rect_ent_t             rd_ent;

    // Combinational helpers.
    logic                     accept;
    logic                     slot_free;
    logic                     emit_fire;
    logic                     store_ok;
    logic signed [EDGE_W-1:0] in_x2;
    logic signed [EDGE_W-1:0] in_y2;
    logic signed [EDGE_W-1:0] fold_a;
    logic signed [EDGE_W-1:0] fold_b;
    sq_t                      sx1, sx2, sy1, sy2;
    sq_t                      hs_a_sq, hs_b_sq, vs_a_sq, vs_b_sq;

    assign in_stall  = (state_reg != S_LOAD);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_fire = (state_reg == S_EMIT) && rd_valid_reg && slot_free;
    assign store_ok  = (count_reg < CNT_W'(MAX_RECTS));

    assign in_x2 = EDGE_W'(rect_x) + $signed({2'b00, rect_width});
    assign in_y2 = EDGE_W'(rect_y) + $signed({2'b00, rect_height});

    // Store write on a loaded rectangle, read walks driven by the issue counter.
    assign st_we         = accept && !action && store_ok;
    assign st_wdata.x    = rect_x;
    assign st_wdata.y    = rect_y;
    assign st_wdata.x2   = in_x2;
    assign st_wdata.y2   = in_y2;
    assign st_re         = (issue_reg < count_reg) &&
                           ((state_reg == S_HASH) ||
                            ((state_reg == S_EMIT) && (!rd_valid_reg || emit_fire)));
    assign rd_ent        = rect_ent_t'(st_rdata);

    ssc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (st_rdata)
    );

    // Squeeze the rectangle that the store just returned.
    assign hs_a_sq = sq_t'(hs_a_reg);
    assign hs_b_sq = sq_t'(hs_b_reg);
    assign vs_a_sq = sq_t'(vs_a_reg);
    assign vs_b_sq = sq_t'(vs_b_reg);
    assign sx1 = squeeze(sq_t'(rd_ent.x), hs_a_sq, hs_b_sq);
    assign sx2 = squeeze(sq_t'(rd_ent.x2), hs_a_sq, hs_b_sq);
    assign sy1 = squeeze(sq_t'(rd_ent.y), vs_a_sq, vs_b_sq);
    assign sy2 = squeeze(sq_t'(rd_ent.y2), vs_a_sq, vs_b_sq);

    // Next-state logic for loading, walking and emitting.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rd_valid_next   = rd_valid_reg;
        rd_last_next    = rd_last_reg;
        sq_valid_next   = 1'b0;
        first_band_next = first_band_reg;
        bw_valid_next   = bw_valid_reg;
        ext_x1_next     = ext_x1_reg;
        ext_y1_next     = ext_y1_reg;
        ext_x2_next     = ext_x2_reg;
        ext_y2_next     = ext_y2_reg;
        vs_a_next       = vs_a_reg;
        vs_b_next       = vs_b_reg;
        vs_len_next     = vs_len_reg;
        hs_a_next       = hs_a_reg;
        hs_b_next       = hs_b_reg;
        bw_a_next       = bw_a_reg;
        bw_b_next       = bw_b_reg;
        bw_len_next     = bw_len_reg;
        hash_next       = hash_reg;
        sq_x1_next      = sq_x1_reg;
        sq_x2_next      = sq_x2_reg;
        sq_y1_next      = sq_y1_reg;
        sq_y2_next      = sq_y2_reg;
        fold_a          = hs_a_reg;
        fold_b          = hs_b_reg;

        out_valid_next  = out_valid_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_w_next      = out_w_reg;
        out_h_next      = out_h_reg;
        bd_top_next     = bd_top_reg;
        bd_right_next   = bd_right_reg;
        bd_bottom_next  = bd_bottom_reg;
        bd_left_next    = bd_left_reg;
        out_hash_next   = out_hash_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && action)
                begin
                    state_next = S_EMPTY;
                end
                else if (accept)
                begin
                    // Extents and the band's widest span follow stored rectangles only.
                    if (store_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == '0)
                        begin
                            ext_x1_next = rect_x;
                            ext_y1_next = rect_y;
                            ext_x2_next = in_x2;
                            ext_y2_next = in_y2;
                        end
                        else
                        begin
                            if (rect_x < ext_x1_reg) ext_x1_next = rect_x;
                            if (rect_y < ext_y1_reg) ext_y1_next = rect_y;
                            if (in_x2 > ext_x2_reg)  ext_x2_next = in_x2;
                            if (in_y2 > ext_y2_reg)  ext_y2_next = in_y2;
                        end
                        if (rect_width > bw_len_reg)
                        begin
                            bw_a_next     = EDGE_W'(rect_x);
                            bw_b_next     = in_x2;
                            bw_len_next   = rect_width;
                            bw_valid_next = 1'b1;
                        end
                    end

                    // Band close: tallest vertical span, then fold the widest span.
                    if (band_end || region_end)
                    begin
                        if (store_ok && (rect_height > vs_len_reg))
                        begin
                            vs_a_next   = EDGE_W'(rect_y);
                            vs_b_next   = in_y2;
                            vs_len_next = rect_height;
                        end
                        if (bw_valid_next)
                        begin
                            if (first_band_reg)
                            begin
                                hs_a_next       = bw_a_next;
                                hs_b_next       = bw_b_next;
                                first_band_next = 1'b0;
                            end
                            else
                            begin
                                if (bw_a_next > hs_a_reg) fold_a = bw_a_next;
                                if (bw_b_next < hs_b_reg) fold_b = bw_b_next;
                                if (fold_b < fold_a)      fold_b = fold_a;
                                hs_a_next = fold_a;
                                hs_b_next = fold_b;
                            end
                        end
                        bw_valid_next = 1'b0;
                        bw_len_next   = '0;
                        bw_a_next     = '0;
                        bw_b_next     = '0;
                    end

                    if (region_end)
                    begin
                        state_next = S_HASH;
                        issue_next = '0;
                    end
                end
            end

            S_EMPTY:
            begin
                // One all-zero result closes an empty region.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    out_w_next     = '0;
                    out_h_next     = '0;
                    bd_top_next    = '0;
                    bd_right_next  = '0;
                    bd_bottom_next = '0;
                    bd_left_next   = '0;
                    out_hash_next  = '0;
                    out_count_next = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_LOAD;
                end
            end

            S_HASH:
            begin
                // Read, squeeze, then fold into the hash, one rectangle per cycle.
                if (st_re)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                rd_valid_next = st_re;
                sq_valid_next = rd_valid_reg;
                if (rd_valid_reg)
                begin
                    sq_x1_next = sx1;
                    sq_x2_next = sx2;
                    sq_y1_next = sy1;
                    sq_y2_next = sy2;
                end
                if (sq_valid_reg)
                begin
                    hash_next = hash_reg * HASH_MUL + hx(sq_x1_reg) * HASH_K_X1 +
                                hx(sq_x2_reg) * HASH_K_X2 + hx(sq_y1_reg) * HASH_K_Y1 +
                                hx(sq_y2_reg) * HASH_K_Y2;
                end
                if ((issue_reg == count_reg) && !rd_valid_reg && !sq_valid_reg)
                begin
                    state_next = S_EMIT;
                    issue_next = '0;
                end
            end

            S_EMIT:
            begin
                // Second walk: one result per free output slot.
                if (st_re)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_last_next  = ((issue_reg + CNT_W'(1)) == count_reg);
                end
                else if (emit_fire)
                begin
                    rd_valid_next = 1'b0;
                end

                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = fld(sx1 - sq_t'(ext_x1_reg));
                    out_y_next     = fld(sy1 - sq_t'(ext_y1_reg));
                    out_w_next     = fld(sx2 - sx1);
                    out_h_next     = fld(sy2 - sy1);
                    bd_top_next    = fld(vs_a_sq - sq_t'(ext_y1_reg));
                    bd_right_next  = fld(sq_t'(ext_x2_reg) - hs_b_sq);
                    bd_bottom_next = fld(sq_t'(ext_y2_reg) - vs_b_sq);
                    bd_left_next   = fld(hs_a_sq - sq_t'(ext_x1_reg));
                    out_hash_next  = hash_reg;
                    out_count_next = COUNT_W'(count_reg);
                    out_last_next  = rd_last_reg;
                    if (rd_last_reg)
                    begin
                        state_next    = S_LOAD;
                        rd_valid_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Run state returns to its reset values after an empty marker or the last result.
        if ((accept && action) || (emit_fire && rd_last_reg))
        begin
            count_next      = '0;
            issue_next      = '0;
            first_band_next = 1'b1;
            bw_valid_next   = 1'b0;
            ext_x1_next     = '0;
            ext_y1_next     = '0;
            ext_x2_next     = '0;
            ext_y2_next     = '0;
            vs_a_next       = '0;
            vs_b_next       = '0;
            vs_len_next     = '0;
            hs_a_next       = '0;
            hs_b_next       = '0;
            bw_a_next       = '0;
            bw_b_next       = '0;
            bw_len_next     = '0;
            hash_next       = '0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            issue_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            sq_valid_reg   <= 1'b0;
            first_band_reg <= 1'b1;
            bw_valid_reg   <= 1'b0;
            ext_x1_reg     <= '0;
            ext_y1_reg     <= '0;
            ext_x2_reg     <= '0;
            ext_y2_reg     <= '0;
            vs_a_reg       <= '0;
            vs_b_reg       <= '0;
            vs_len_reg     <= '0;
            hs_a_reg       <= '0;
            hs_b_reg       <= '0;
            bw_a_reg       <= '0;
            bw_b_reg       <= '0;
            bw_len_reg     <= '0;
            hash_reg       <= '0;
            sq_x1_reg      <= '0;
            sq_x2_reg      <= '0;
            sq_y1_reg      <= '0;
            sq_y2_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_w_reg      <= '0;
            out_h_reg      <= '0;
            bd_top_reg     <= '0;
            bd_right_reg   <= '0;
            bd_bottom_reg  <= '0;
            bd_left_reg    <= '0;
            out_hash_reg   <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            sq_valid_reg   <= sq_valid_next;
            first_band_reg <= first_band_next;
            bw_valid_reg   <= bw_valid_next;
            ext_x1_reg     <= ext_x1_next;
            ext_y1_reg     <= ext_y1_next;
            ext_x2_reg     <= ext_x2_next;
            ext_y2_reg     <= ext_y2_next;
            vs_a_reg       <= vs_a_next;
            vs_b_reg       <= vs_b_next;
            vs_len_reg     <= vs_len_next;
            hs_a_reg       <= hs_a_next;
            hs_b_reg       <= hs_b_next;
            bw_a_reg       <= bw_a_next;
            bw_b_reg       <= bw_b_next;
            bw_len_reg     <= bw_len_next;
            hash_reg       <= hash_next;
            sq_x1_reg      <= sq_x1_next;
            sq_x2_reg      <= sq_x2_next;
            sq_y1_reg      <= sq_y1_next;
            sq_y2_reg      <= sq_y2_next;
            out_valid_reg  <= out_valid_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_w_reg      <= out_w_next;
            out_h_reg      <= out_h_next;
            bd_top_reg     <= bd_top_next;
            bd_right_reg   <= bd_right_next;
            bd_bottom_reg  <= bd_bottom_next;
            bd_left_reg    <= bd_left_next;
            out_hash_reg   <= out_hash_next;
            out_count_reg  <= out_count_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Output ports.
    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_width     = out_w_reg;
    assign out_height    = out_h_reg;
    assign margin_top    = bd_top_reg;
    assign margin_right  = bd_right_reg;
    assign margin_bottom = bd_bottom_reg;
    assign margin_left   = bd_left_reg;
    assign shape_hash    = out_hash_reg;
    assign rect_count    = out_count_reg;
    assign last_result   = out_last_reg;

    // Internal consistency checks.
    `SSC_CHECK_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_RECTS), "store count overflow")
    `SSC_CHECK_NOW(a_issue_bound, (state_reg == S_HASH) || (state_reg == S_EMIT), issue_reg <= count_reg, "read walk ran past the count")
    `SSC_CHECK_NOW(a_hash_drained, state_reg == S_EMIT, !sq_valid_reg, "hash pipeline busy during emit")
    `SSC_CHECK_NEXT(a_held_read, (state_reg == S_EMIT) && rd_valid_reg && !slot_free, rd_valid_reg && (state_reg == S_EMIT), "pending read lost under stall")
    `SSC_CHECK_NEXT(a_last_resets, emit_fire && rd_last_reg, (state_reg == S_LOAD) && (count_reg == '0), "run state not cleared after last result")

endmodule

/* tb/shape_span_compressor_core_tb.sv */
// Self-checking testbench for the shape span compressor core.
module shape_span_compressor_core_tb;
    import ssc_pkg::*;

    localparam int BOX_DEPTH    = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 160;
    localparam int RANDOM_ITEMS = 400;
    localparam int TOTAL_ITEMS  = 450;

    localparam logic ACT_RECT  = 1'b0;
    localparam logic ACT_EMPTY = 1'b1;

    localparam logic [31:0] MIX_MUL = 32'd31;
    localparam logic [31:0] MIX_X1  = 32'd17;
    localparam logic [31:0] MIX_X2  = 32'd27;
    localparam logic [31:0] MIX_Y1  = 32'd37;
    localparam logic [31:0] MIX_Y2  = 32'd43;

    // One input request as presented on the ports.
    typedef struct packed {
        logic                      act;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic                      be;
        logic                      re;
    } shape_req_t;

    // One rectangle held for the emit pass.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } box_t;

    // One compressed rectangle as it should leave the block.
    typedef struct packed {
        logic [FIELD_W-1:0] px;
        logic [FIELD_W-1:0] py;
        logic [FIELD_W-1:0] pw;
        logic [FIELD_W-1:0] ph;
        logic [FIELD_W-1:0] bt;
        logic [FIELD_W-1:0] br;
        logic [FIELD_W-1:0] bb;
        logic [FIELD_W-1:0] bl;
        logic [HASH_W-1:0]  hash;
        logic [COUNT_W-1:0] count;
        logic               last;
    } shape_res_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic                      action      = ACT_RECT;
    logic signed [COORD_W-1:0] rect_x      = '0;
    logic signed [COORD_W-1:0] rect_y      = '0;
    logic [SIZE_W-1:0]         rect_width  = '0;
    logic [SIZE_W-1:0]         rect_height = '0;
    logic                      band_end    = 1'b0;
    logic                      region_end  = 1'b0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [FIELD_W-1:0]        out_x;
    logic [FIELD_W-1:0]        out_y;
    logic [FIELD_W-1:0]        out_width;
    logic [FIELD_W-1:0]        out_height;
    logic [FIELD_W-1:0]        margin_top;
    logic [FIELD_W-1:0]        margin_right;
    logic [FIELD_W-1:0]        margin_bottom;
    logic [FIELD_W-1:0]        margin_left;
    logic [HASH_W-1:0]         shape_hash;
    logic [COUNT_W-1:0]        rect_count;
    logic                      last_result;

    // Predictor state: stored rectangles, extents and spans of the region being loaded.
    box_t held_boxes[BOX_DEPTH];
    int   held_count;
    int   ext_left, ext_top, ext_right, ext_bottom;
    int   tall_lo, tall_hi;
    int   common_lo, common_hi;
    int   widest_lo, widest_hi;
    bit   widest_ok;
    bit   first_band_open;

    shape_res_t compressed_due[$];
    shape_res_t result_want;

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int out_stall_left = 0;
    bit in_gaps_on     = 1'b0;
    bit out_gaps_on    = 1'b0;

    shape_span_compressor_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .band_end     (band_end),
        .region_end   (region_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_width    (out_width),
        .out_height   (out_height),
        .margin_top   (margin_top),
        .margin_right (margin_right),
        .margin_bottom(margin_bottom),
        .margin_left  (margin_left),
        .shape_hash   (shape_hash),
        .rect_count   (rect_count),
        .last_result  (last_result)
    );

    // Free-running clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is cut off if it never drains.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Output back-pressure in random bursts while enabled.
    always @(posedge clk)
    begin
        if (out_gaps_on && out_stall_left == 0 && $urandom_range(0, 3) == 0)
            out_stall_left = $urandom_range(1, 5);
        if (out_stall_left > 0)
        begin
            out_stall <= 1'b1;
            out_stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0d] error: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Every accepted result is compared against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (compressed_due.size() == 0)
            begin
                report_mismatch("result arrived with nothing expected");
            end
            else
            begin
                result_want = compressed_due.pop_front();
                check_field("out_x", out_x, result_want.px);
                check_field("out_y", out_y, result_want.py);
                check_field("out_width", out_width, result_want.pw);
                check_field("out_height", out_height, result_want.ph);
                check_field("margin_top", margin_top, result_want.bt);
                check_field("margin_right", margin_right, result_want.br);
                check_field("margin_bottom", margin_bottom, result_want.bb);
                check_field("margin_left", margin_left, result_want.bl);
                check_field("shape_hash", shape_hash, result_want.hash);
                check_field("rect_count", rect_count, result_want.count);
                check_field("last_result", last_result, result_want.last);
            end
        end
    end

    // Return the region state to its idle values.
    function automatic void clear_run();
        held_count      = 0;
        ext_left        = 0;
        ext_top         = 0;
        ext_right       = 0;
        ext_bottom      = 0;
        tall_lo         = 0;
        tall_hi         = 0;
        common_lo       = 0;
        common_hi       = 0;
        widest_lo       = 0;
        widest_hi       = 0;
        widest_ok       = 1'b0;
        first_band_open = 1'b1;
    endfunction

    // Collapse the part of a coordinate that falls inside the span [lo, hi).
    function automatic int collapse(input int v, input int lo, input int hi);
        int lim;
        int res;
        lim = hi - 1;
        res = v;
        if (v > lo)
            res = v - (((v < lim) ? v : lim) - lo);
        return res;
    endfunction

    // Close a band: the tallest closing rectangle sets the vertical span and the band's
    // widest span narrows the common horizontal span.
    function automatic void fold_band(input bit has_box, input int top, input int tall);
        if (has_box && tall > tall_hi - tall_lo)
        begin
            tall_lo = top;
            tall_hi = top + tall;
        end
        if (widest_ok)
        begin
            if (first_band_open)
            begin
                common_lo       = widest_lo;
                common_hi       = widest_hi;
                first_band_open = 1'b0;
            end
            else
            begin
                if (widest_lo > common_lo)
                    common_lo = widest_lo;
                if (widest_hi < common_hi)
                    common_hi = widest_hi;
                if (common_hi < common_lo)
                    common_hi = common_lo;
            end
        end
        widest_ok = 1'b0;
        widest_lo = 0;
        widest_hi = 0;
    endfunction

    // Work out every compressed rectangle of the finished region.
    function automatic void emit_region();
        shape_res_t  rows[BOX_DEPTH];
        logic [31:0] digest;
        int          x1, x2, y1, y2, left, top;
        digest = '0;
        for (int k = 0; k < held_count; k++)
        begin
            left = $signed(held_boxes[k].x);
            top  = $signed(held_boxes[k].y);
            x1 = collapse(left, common_lo, common_hi);
            x2 = collapse(left + int'(held_boxes[k].w), common_lo, common_hi);
            y1 = collapse(top, tall_lo, tall_hi);
            y2 = collapse(top + int'(held_boxes[k].h), tall_lo, tall_hi);
            rows[k].px = 16'(x1 - ext_left);
            rows[k].py = 16'(y1 - ext_top);
            rows[k].pw = 16'(x2 - x1);
            rows[k].ph = 16'(y2 - y1);
            digest = digest * MIX_MUL + 32'(x1) * MIX_X1 + 32'(x2) * MIX_X2
                   + 32'(y1) * MIX_Y1 + 32'(y2) * MIX_Y2;
        end
        for (int k = 0; k < held_count; k++)
        begin
            rows[k].bt    = 16'(tall_lo - ext_top);
            rows[k].br    = 16'(ext_right - common_hi);
            rows[k].bb    = 16'(ext_bottom - tall_hi);
            rows[k].bl    = 16'(common_lo - ext_left);
            rows[k].hash  = digest;
            rows[k].count = 7'(held_count);
            rows[k].last  = (k == held_count - 1);
            compressed_due.push_back(rows[k]);
        end
        clear_run();
    endfunction

    // Advance the predictor by one accepted request.
    function automatic void predict_compression(input shape_req_t req);
        shape_res_t blank;
        int         left, top, right, bottom;
        if (req.act == ACT_EMPTY)
        begin
            blank      = '0;
            blank.last = 1'b1;
            compressed_due.push_back(blank);
            clear_run();
            return;
        end
        left   = $signed(req.x);
        top    = $signed(req.y);
        right  = left + int'(req.w);
        bottom = top + int'(req.h);
        if (held_count < BOX_DEPTH)
        begin
            if (held_count == 0)
            begin
                ext_left   = left;
                ext_top    = top;
                ext_right  = right;
                ext_bottom = bottom;
            end
            else
            begin
                if (left < ext_left)
                    ext_left = left;
                if (top < ext_top)
                    ext_top = top;
                if (right > ext_right)
                    ext_right = right;
                if (bottom > ext_bottom)
                    ext_bottom = bottom;
            end
            held_boxes[held_count].x = req.x;
            held_boxes[held_count].y = req.y;
            held_boxes[held_count].w = req.w;
            held_boxes[held_count].h = req.h;
            held_count++;
            if (int'(req.w) > widest_hi - widest_lo)
            begin
                widest_lo = left;
                widest_hi = right;
                widest_ok = 1'b1;
            end
            if (req.be || req.re)
                fold_band(1'b1, top, int'(req.h));
        end
        else if (req.be || req.re)
        begin
            // A full store still lets the band close, without a rectangle.
            fold_band(1'b0, 0, 0);
        end
        if (req.re)
            emit_region();
    endfunction

    // Present one request, hold it until accepted, then update the predictor.
    task automatic send_item(input logic act, input int x, input int y, input int w,
                             input int h, input logic be, input logic re);
        shape_req_t req;
        int         gap;
        req.act = act;
        req.x   = 16'(x);
        req.y   = 16'(y);
        req.w   = 15'(w);
        req.h   = 15'(h);
        req.be  = be;
        req.re  = re;
        if (in_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= req.act;
        rect_x      <= req.x;
        rect_y      <= req.y;
        rect_width  <= req.w;
        rect_height <= req.h;
        band_end    <= req.be;
        region_end  <= req.re;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_compression(req);
        items_sent++;
    endtask

    // Empty region marker with every payload bit set, straight after reset.
    task automatic test_empty_marker();
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        send_item(ACT_EMPTY, -1, -1, 32'h7fff, 32'h7fff, 1'b1, 1'b1);
    endtask

    // Corners and sizes at the ends of their ranges; the second region lacks a band end.
    task automatic test_field_extremes();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        send_item(ACT_RECT, -32768, -32768, 32767, 32767, 1'b1, 1'b1);
        send_item(ACT_RECT, 32767, 32767, 1, 1, 1'b0, 1'b1);
        send_item(ACT_RECT, 32767, -32768, 32767, 1, 1'b1, 1'b0);
        send_item(ACT_RECT, -32768, 32767, 1, 32767, 1'b1, 1'b1);
    endtask

    // Several bands whose widest spans overlap, miss each other, and tie in width.
    task automatic test_band_folding();
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
        send_item(ACT_RECT, 0, 0, 10, 5, 1'b0, 1'b0);
        send_item(ACT_RECT, 20, 0, 30, 5, 1'b1, 1'b0);
        send_item(ACT_RECT, 5, 5, 40, 7, 1'b0, 1'b0);
        send_item(ACT_RECT, 50, 5, 3, 7, 1'b1, 1'b1);
        // Widest spans that do not meet pinch the common span to nothing.
        send_item(ACT_RECT, 0, 10, 10, 4, 1'b1, 1'b0);
        send_item(ACT_RECT, 100, 14, 5, 4, 1'b1, 1'b1);
        // An equal width does not replace the first widest rectangle.
        send_item(ACT_RECT, 0, 0, 8, 2, 1'b0, 1'b0);
        send_item(ACT_RECT, 10, 0, 8, 2, 1'b1, 1'b1);
        send_item(ACT_RECT, -100, -50, 30, 20, 1'b0, 1'b0);
        send_item(ACT_RECT, -60, -50, 30, 20, 1'b1, 1'b0);
        send_item(ACT_RECT, -100, -30, 70, 10, 1'b1, 1'b1);
    endtask

    // A partly loaded region is thrown away by an empty marker.
    task automatic test_partial_discard();
        send_item(ACT_RECT, 3, 3, 4, 4, 1'b1, 1'b0);
        send_item(ACT_RECT, 9, 3, 2, 4, 1'b0, 1'b0);
        send_item(ACT_EMPTY, 0, 0, 0, 0, 1'b0, 1'b0);
        send_item(ACT_RECT, -5, -7, 12, 9, 1'b1, 1'b1);
    endtask

    // Fill the store, then close a band of ignored rectangles and end on an ignored one.
    task automatic test_store_overflow();
        int cur_x;
        int cur_y;
        int w;
        cur_y = $urandom_range(0, 100) - 50;
        for (int b = 0; b < BOX_DEPTH / 4; b++)
        begin
            cur_x = $urandom_range(0, 40);
            for (int r = 0; r < 4; r++)
            begin
                w = $urandom_range(1, 30);
                send_item(ACT_RECT, cur_x, cur_y, w, 6, r == 3, 1'b0);
                cur_x += w + $urandom_range(0, 5);
            end
            cur_y += 6;
        end
        send_item(ACT_RECT, 0, cur_y, 500, 9, 1'b0, 1'b0);
        send_item(ACT_RECT, 600, cur_y, 3, 9, 1'b0, 1'b0);
        send_item(ACT_RECT, 700, cur_y, 90, 9, 1'b1, 1'b0);
        send_item(ACT_RECT, 800, cur_y + 9, 20, 40, 1'b0, 1'b1);
    endtask

    // One region of random bands; now and then scattered, cut short or badly closed.
    task automatic send_random_region();
        int n_bands, per_band, band_h, cur_x, cur_y, w, h, total, abort_at;
        bit scatter, big, drop_close;
        logic be, re;
        scatter    = ($urandom_range(0, 5) == 0);
        big        = ($urandom_range(0, 39) == 0);
        drop_close = ($urandom_range(0, 7) == 0);
        abort_at   = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 3) : -1;
        n_bands    = big ? $urandom_range(16, 18) : $urandom_range(1, 4);
        cur_y      = $urandom_range(0, 400) - 200;
        total      = 0;
        for (int b = 0; b < n_bands; b++)
        begin
            per_band = big ? 4 : $urandom_range(1, 4);
            band_h   = $urandom_range(1, 30);
            cur_x    = $urandom_range(0, 400) - 200;
            for (int r = 0; r < per_band; r++)
            begin
                if (total == abort_at)
                begin
                    send_item(ACT_EMPTY, $urandom, $urandom, $urandom, $urandom,
                              1'($urandom), 1'($urandom));
                    return;
                end
                re = (b == n_bands - 1) && (r == per_band - 1);
                be = (r == per_band - 1) || ($urandom_range(0, 9) == 0);
                if (re && drop_close)
                    be = 1'b0;
                if (scatter)
                begin
                    send_item(ACT_RECT, $urandom, $urandom, $urandom_range(1, 32767),
                              $urandom_range(1, 32767), be, re);
                end
                else
                begin
                    w = $urandom_range(1, 40);
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : band_h;
                    cur_x += $urandom_range(0, 20);
                    send_item(ACT_RECT, cur_x, cur_y, w, h, be, re);
                    cur_x += w;
                end
                total++;
            end
            cur_y += band_h + $urandom_range(0, 10);
        end
    endtask

    // Random regions with idling switched on and off per region.
    task automatic test_random_regions();
        while (items_sent < RANDOM_ITEMS)
        begin
            in_gaps_on  = ($urandom_range(0, 5) != 0);
            out_gaps_on = ($urandom_range(0, 5) != 0);
            send_random_region();
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_quiet_tail();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        while (items_sent < TOTAL_ITEMS)
            send_random_region();
    endtask

    // Reset, run every test, drain and give the verdict.
    initial
    begin
        clear_run();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_marker();
        test_field_extremes();
        test_band_folding();
        test_partial_discard();
        test_store_overflow();
        test_random_regions();
        test_quiet_tail();
        in_valid <= 1'b0;
        while (compressed_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/ssc_pkg.sv
src/ssc_ram.sv
src/shape_span_compressor_core.sv
tb/shape_span_compressor_core_tb.sv
